// ----- hdl/spa_pkg.sv -----
`timescale 1ns / 1ps

package spa_pkg;

   localparam int SLOTS  = 256;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int LINK_W = SLOT_W + 1;
   localparam int CNT_W  = $clog2(SLOTS + 1);

   typedef logic [SLOT_W-1:0] slot_type;
   typedef logic [LINK_W-1:0] link_type;
   typedef logic [CNT_W-1:0]  count_type;

   // null link: only the top bit set
   localparam link_type  NIL_LINK    = link_type'(1) << SLOT_W;
   localparam count_type SLOTS_COUNT = count_type'(SLOTS);

   localparam logic [2:0] MODE_ALLOC = 3'd0;
   localparam logic [2:0] MODE_FREE  = 3'd1;
   localparam logic [2:0] MODE_FIRST = 3'd2;
   localparam logic [2:0] MODE_NEXT  = 3'd3;
   localparam logic [2:0] MODE_QUERY = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NONE    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;

endpackage

// ----- hdl/spa_link_ram.sv -----
`timescale 1ns / 1ps

module spa_link_ram #(
   parameter int DATA_W = 9,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write-first: a read at the address written in the same cycle sees the new data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/slot_pool_allocator_unit.sv -----
`timescale 1ns / 1ps

// Slot pool allocator. Hands out slot indexes from a LIFO free list and keeps
// the slots in use on a doubly linked list, newest first. Every request gives
// exactly one response. A request enters a link-memory read stage when taken,
// is executed from there once the response register can take it, and its
// response is registered there; one request can be taken every cycle while
// responses are not held back by rsp_ready, set by the
// single write port of each link memory and the write-first bypass between
// back-to-back requests. A write with csr_write_en sets the pool size (0 acts
// as 1, above 256 as 256) and empties the pool in that same cycle; write it
// only while no request is in flight.

module slot_pool_allocator_unit
   import spa_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_mode,
   input  logic [7:0] req_slot_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_status,
   output logic [7:0] rsp_slot_out,
   output logic       rsp_slot_in_use,
   output logic [8:0] rsp_used_count,
   input  logic       csr_write_en,
   input  logic [8:0] csr_write_data
);

   logic             req_xfer;
   logic             exec_go;

   logic             exec_vld_ff, exec_vld_in;
   logic [2:0]       exec_mode_ff;
   slot_type         exec_slot_ff;

   logic             rsp_vld_ff, rsp_vld_in;
   logic [1:0]       rsp_status_ff;
   slot_type         rsp_slot_ff;
   logic             rsp_flag_ff;
   count_type        rsp_count_ff;

   count_type        pool_n_ff, pool_n_cfg;
   count_type        fresh_ff, fresh_in;
   link_type         stack_head_ff, stack_head_in;
   link_type         used_head_ff, used_head_in;
   count_type        count_ff, count_in;
   logic [SLOTS-1:0] in_use_ff, in_use_in;

   logic             unext_we, prev_we, fnext_we;
   slot_type         unext_wa, prev_wa, fnext_wa;
   link_type         unext_wd, prev_wd, fnext_wd;
   link_type         unext_rd, prev_rd, fnext_rd;

   logic [1:0]       status;
   slot_type         slot_out;
   logic             flag_out;

   assign exec_go   = exec_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !exec_vld_ff || exec_go;
   assign req_xfer  = req_valid && req_ready;

   // used-list forward links
   spa_link_ram #(.DATA_W(LINK_W), .ADDR_W(SLOT_W)) u_used_next (
      .clock   (clock),
      .wr_en   (unext_we),
      .wr_addr (unext_wa),
      .wr_data (unext_wd),
      .rd_en   (req_xfer),
      .rd_addr (req_slot_in),
      .rd_data (unext_rd)
   );

   // used-list back links; the head's back link may be stale and is never followed
   spa_link_ram #(.DATA_W(LINK_W), .ADDR_W(SLOT_W)) u_prev (
      .clock   (clock),
      .wr_en   (prev_we),
      .wr_addr (prev_wa),
      .wr_data (prev_wd),
      .rd_en   (req_xfer),
      .rd_addr (req_slot_in),
      .rd_data (prev_rd)
   );

   // freed-slot stack links; slots never handed out come from the fresh counter
   spa_link_ram #(.DATA_W(LINK_W), .ADDR_W(SLOT_W)) u_free_next (
      .clock   (clock),
      .wr_en   (fnext_we),
      .wr_addr (fnext_wa),
      .wr_data (fnext_wd),
      .rd_en   (req_xfer),
      .rd_addr (stack_head_in[SLOT_W-1:0]),
      .rd_data (fnext_rd)
   );

   always_comb begin
      if (csr_write_data == '0) begin
         pool_n_cfg = count_type'(1);
      end else if (csr_write_data > SLOTS_COUNT) begin
         pool_n_cfg = SLOTS_COUNT;
      end else begin
         pool_n_cfg = csr_write_data;
      end
   end

   always_comb begin
      logic     in_range;
      logic     slot_ok;
      logic     alloc_ok;
      slot_type e;

      in_range = {1'b0, exec_slot_ff} < pool_n_ff;
      slot_ok  = in_range && in_use_ff[exec_slot_ff];
      alloc_ok = 1'b0;
      e        = '0;

      fresh_in      = fresh_ff;
      stack_head_in = stack_head_ff;
      used_head_in  = used_head_ff;
      count_in      = count_ff;
      in_use_in     = in_use_ff;
      unext_we      = 1'b0;
      unext_wa      = exec_slot_ff;
      unext_wd      = used_head_ff;
      prev_we       = 1'b0;
      prev_wa       = exec_slot_ff;
      prev_wd       = prev_rd;
      fnext_we      = 1'b0;
      fnext_wa      = exec_slot_ff;
      fnext_wd      = stack_head_ff;
      status        = ST_OK;
      slot_out      = '0;
      flag_out      = 1'b0;

      if (exec_go) begin
         unique case (exec_mode_ff)
            MODE_ALLOC: begin
               if (stack_head_ff != NIL_LINK) begin
                  e             = stack_head_ff[SLOT_W-1:0];
                  stack_head_in = fnext_rd;
                  alloc_ok      = 1'b1;
               end else if (fresh_ff < pool_n_ff) begin
                  e        = fresh_ff[SLOT_W-1:0];
                  fresh_in = fresh_ff + count_type'(1);
                  alloc_ok = 1'b1;
               end else begin
                  status = ST_NONE;
               end
               if (alloc_ok) begin
                  unext_we = 1'b1;
                  unext_wa = e;
                  unext_wd = used_head_ff;
                  if (used_head_ff != NIL_LINK) begin
                     prev_we = 1'b1;
                     prev_wa = used_head_ff[SLOT_W-1:0];
                     prev_wd = {1'b0, e};
                  end
                  used_head_in = {1'b0, e};
                  in_use_in[e] = 1'b1;
                  count_in     = count_ff + count_type'(1);
                  slot_out     = e;
               end
            end
            MODE_FREE: begin
               if (!slot_ok) begin
                  status = ST_INVALID;
               end else begin
                  // unlink: prev_rd is the back link, unext_rd the forward link
                  if (used_head_ff == {1'b0, exec_slot_ff}) begin
                     used_head_in = unext_rd;
                  end else if (prev_rd != NIL_LINK) begin
                     unext_we = 1'b1;
                     unext_wa = prev_rd[SLOT_W-1:0];
                     unext_wd = unext_rd;
                  end
                  if (unext_rd != NIL_LINK) begin
                     prev_we = 1'b1;
                     prev_wa = unext_rd[SLOT_W-1:0];
                     prev_wd = prev_rd;
                  end
                  fnext_we                = 1'b1;
                  stack_head_in           = {1'b0, exec_slot_ff};
                  in_use_in[exec_slot_ff] = 1'b0;
                  if (count_ff != '0) begin
                     count_in = count_ff - count_type'(1);
                  end
               end
            end
            MODE_FIRST: begin
               if (used_head_ff == NIL_LINK) begin
                  status = ST_NONE;
               end else begin
                  slot_out = used_head_ff[SLOT_W-1:0];
               end
            end
            MODE_NEXT: begin
               if (!slot_ok) begin
                  status = ST_INVALID;
               end else if (unext_rd == NIL_LINK) begin
                  status = ST_NONE;
               end else begin
                  slot_out = unext_rd[SLOT_W-1:0];
               end
            end
            MODE_QUERY: begin
               if (!in_range) begin
                  status = ST_INVALID;
               end else begin
                  flag_out = in_use_ff[exec_slot_ff];
               end
            end
            default: begin
               status = ST_INVALID;
            end
         endcase
      end
   end

   always_comb begin
      exec_vld_in = exec_vld_ff;
      if (req_xfer) begin
         exec_vld_in = 1'b1;
      end else if (exec_go) begin
         exec_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (exec_go) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exec_vld_ff   <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         pool_n_ff     <= SLOTS_COUNT;
         fresh_ff      <= '0;
         stack_head_ff <= NIL_LINK;
         used_head_ff  <= NIL_LINK;
         count_ff      <= '0;
         in_use_ff     <= '0;
      end else begin
         exec_vld_ff <= exec_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
         if (csr_write_en) begin
            pool_n_ff     <= pool_n_cfg;
            fresh_ff      <= '0;
            stack_head_ff <= NIL_LINK;
            used_head_ff  <= NIL_LINK;
            count_ff      <= '0;
            in_use_ff     <= '0;
         end else begin
            fresh_ff      <= fresh_in;
            stack_head_ff <= stack_head_in;
            used_head_ff  <= used_head_in;
            count_ff      <= count_in;
            in_use_ff     <= in_use_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         exec_mode_ff <= req_mode;
         exec_slot_ff <= req_slot_in;
      end
      if (exec_go) begin
         rsp_status_ff <= status;
         rsp_slot_ff   <= slot_out;
         rsp_flag_ff   <= flag_out;
         rsp_count_ff  <= count_in;
      end
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot_out    = rsp_slot_ff;
   assign rsp_slot_in_use = rsp_flag_ff;
   assign rsp_used_count  = rsp_count_ff;

endmodule

// ----- verif/slot_pool_allocator_unit_tb.sv -----
`timescale 1ns / 1ps

module slot_pool_allocator_unit_tb;
   import spa_pkg::*;

   localparam logic [2:0] MODE_UNDEF_LO  = 3'd5;
   localparam logic [2:0] MODE_UNDEF_MID = 3'd6;
   localparam logic [2:0] MODE_UNDEF_HI  = 3'd7;
   localparam int IDLE_LIMIT  = 2000;
   localparam int DRAIN_TICKS = 4;

   typedef struct packed {
      logic [2:0] mode;
      slot_type   slot;
   } pool_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      slot_type   slot_out;
      logic       in_use;
      count_type  count;
   } pool_rsp_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [2:0] req_mode = MODE_ALLOC;
   logic [7:0] req_slot_in = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b1;
   logic [1:0] rsp_status;
   logic [7:0] rsp_slot_out;
   logic       rsp_slot_in_use;
   logic [8:0] rsp_used_count;
   logic       csr_write_en = 1'b0;
   logic [8:0] csr_write_data = '0;

   // pool images: index 0 follows the command generator, index 1 the DUT
   link_type  nxt_lnk   [2][SLOTS];
   link_type  prv_lnk   [2][SLOTS];
   bit        used_flag [2][SLOTS];
   link_type  used_hd   [2];
   link_type  free_hd   [2];
   count_type used_cnt  [2];
   int        pool_n    [2];
   link_type  walk_pos;

   pool_cmd_type pending_cmds [$];
   pool_rsp_type expected_rsps [$];

   int fail_cnt = 0;
   int idle_cycles = 0;
   int req_gap = 0;
   int rsp_hold = 0;
   int issued_cnt = 0;
   int done_cnt = 0;
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   slot_pool_allocator_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_slot_in     (req_slot_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_slot_out    (rsp_slot_out),
      .rsp_slot_in_use (rsp_slot_in_use),
      .rsp_used_count  (rsp_used_count),
      .csr_write_en    (csr_write_en),
      .csr_write_data  (csr_write_data)
   );

   always #6 clock = ~clock;

   function automatic void pool_init(input int c, input logic [8:0] size);
      int n;
      n = size;
      if (n < 1) n = 1;
      if (n > SLOTS) n = SLOTS;
      pool_n[c] = n;
      for (int i = 0; i < SLOTS; i++) begin
         nxt_lnk[c][i]   = (i + 1 < n) ? link_type'(i + 1) : NIL_LINK;
         prv_lnk[c][i]   = NIL_LINK;
         used_flag[c][i] = 1'b0;
      end
      used_hd[c]  = NIL_LINK;
      free_hd[c]  = '0;
      used_cnt[c] = '0;
   endfunction

   function automatic bit slot_live(input int c, input slot_type s);
      return (int'(s) < pool_n[c]) && used_flag[c][s];
   endfunction

   function automatic pool_rsp_type pool_step(input int c, input logic [2:0] m, input slot_type s);
      pool_rsp_type r;
      link_type  e;
      link_type  p;
      link_type  nx;
      r = '0;
      r.status = ST_OK;
      case (m)
         MODE_ALLOC: begin
            e = free_hd[c];
            if (e == NIL_LINK) begin
               r.status = ST_NONE;
            end else begin
               free_hd[c] = nxt_lnk[c][e[SLOT_W-1:0]];
               prv_lnk[c][e[SLOT_W-1:0]] = NIL_LINK;
               nxt_lnk[c][e[SLOT_W-1:0]] = used_hd[c];
               if (used_hd[c] != NIL_LINK) prv_lnk[c][used_hd[c][SLOT_W-1:0]] = e;
               used_hd[c] = e;
               used_flag[c][e[SLOT_W-1:0]] = 1'b1;
               used_cnt[c] = used_cnt[c] + 1'b1;
               r.slot_out = e[SLOT_W-1:0];
            end
         end
         MODE_FREE: begin
            if (!slot_live(c, s)) begin
               r.status = ST_INVALID;
            end else begin
               p  = prv_lnk[c][s];
               nx = nxt_lnk[c][s];
               if (used_hd[c] == link_type'(s)) used_hd[c] = nx;
               else if (p != NIL_LINK) nxt_lnk[c][p[SLOT_W-1:0]] = nx;
               if (nx != NIL_LINK)
                  prv_lnk[c][nx[SLOT_W-1:0]] = (used_hd[c] == nx) ? NIL_LINK : p;
               prv_lnk[c][s] = NIL_LINK;
               nxt_lnk[c][s] = free_hd[c];
               free_hd[c] = link_type'(s);
               used_flag[c][s] = 1'b0;
               if (used_cnt[c] > 0) used_cnt[c] = used_cnt[c] - 1'b1;
            end
         end
         MODE_FIRST: begin
            if (used_hd[c] == NIL_LINK) r.status = ST_NONE;
            else r.slot_out = used_hd[c][SLOT_W-1:0];
         end
         MODE_NEXT: begin
            if (!slot_live(c, s)) r.status = ST_INVALID;
            else if (nxt_lnk[c][s] == NIL_LINK) r.status = ST_NONE;
            else r.slot_out = nxt_lnk[c][s][SLOT_W-1:0];
         end
         MODE_QUERY: begin
            if (int'(s) >= pool_n[c]) r.status = ST_INVALID;
            else r.in_use = used_flag[c][s];
         end
         default: begin
            r.status = ST_INVALID;
         end
      endcase
      r.count = used_cnt[c];
      return r;
   endfunction

   function automatic void push_req(input logic [2:0] m, input slot_type s);
      pool_cmd_type cmd;
      pool_rsp_type r;
      cmd.mode = m;
      cmd.slot = s;
      r = pool_step(0, m, s);
      if (m == MODE_FIRST || m == MODE_NEXT)
         walk_pos = (r.status == ST_OK) ? link_type'(r.slot_out) : NIL_LINK;
      pending_cmds.push_back(cmd);
   endfunction

   function automatic slot_type pick_used();
      int t;
      for (int k = 0; k < 8; k++) begin
         t = $urandom_range(0, pool_n[0] - 1);
         if (used_flag[0][t]) return slot_type'(t);
      end
      if (used_hd[0] != NIL_LINK) return used_hd[0][SLOT_W-1:0];
      return slot_type'($urandom_range(0, pool_n[0] - 1));
   endfunction

   // mostly legal traffic against the generator image, a little noise
   function automatic void push_random(input int alloc_pct);
      int         roll;
      int         pick;
      logic [2:0] m;
      slot_type   s;
      roll = $urandom_range(0, 99);
      m = MODE_QUERY;
      s = slot_type'($urandom);
      if (roll < alloc_pct) begin
         m = MODE_ALLOC;
      end else if (roll < alloc_pct + (94 - alloc_pct) / 2) begin
         m = MODE_FREE;
         s = pick_used();
      end else if (roll < 94) begin
         pick = $urandom_range(0, 4);
         if (pick == 0) begin
            m = MODE_FIRST;
         end else if (pick < 4) begin
            m = MODE_NEXT;
            s = (walk_pos != NIL_LINK) ? walk_pos[SLOT_W-1:0] : pick_used();
         end else begin
            s = slot_type'($urandom_range(0, pool_n[0] - 1));
         end
      end else begin
         m = 3'($urandom_range(0, 7));
      end
      push_req(m, s);
   endfunction

   function automatic int draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 16);
   endfunction

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         fail_cnt++;
      end
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || issued_cnt != done_cnt)
         @(posedge clock);
      repeat (DRAIN_TICKS) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [8:0] size);
      wait_drained();
      csr_write_en   <= 1'b1;
      csr_write_data <= size;
      @(posedge clock);
      csr_write_en <= 1'b0;
      pool_init(0, size);
      pool_init(1, size);
      walk_pos = NIL_LINK;
   endtask

   task automatic run_phase(input logic [8:0] size, input int items, input int alloc_pct);
      write_pool_size(size);
      repeat (items) push_random(alloc_pct);
   endtask

   always @(posedge clock) begin : drive_req
      pool_cmd_type cmd;
      bit        live;
      live = req_valid;
      if (req_valid && req_ready) begin
         expected_rsps.push_back(pool_step(1, req_mode, req_slot_in));
         live = 1'b0;
         if ($urandom_range(0, 19) == 0) req_calm = !req_calm;
         req_gap = draw_gap(req_calm);
      end
      if (!live && !reset) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_cmds.size() > 0) begin
            cmd = pending_cmds.pop_front();
            issued_cnt++;
            req_mode    <= cmd.mode;
            req_slot_in <= cmd.slot;
            live = 1'b1;
         end
      end
      req_valid <= live;
   end

   always @(posedge clock) begin : watch_rsp
      pool_rsp_type want;
      if (rsp_valid && rsp_ready) begin
         done_cnt++;
         if (expected_rsps.size() == 0) begin
            $display("%0t: unexpected transfer, expected none, actual status %0d slot %0d",
                     $time, rsp_status, rsp_slot_out);
            fail_cnt++;
         end else begin
            want = expected_rsps.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("slot_out", want.slot_out, rsp_slot_out);
            check_field("slot_in_use", want.in_use, rsp_slot_in_use);
            check_field("used_count", want.count, rsp_used_count);
         end
         if ($urandom_range(0, 19) == 0) rsp_calm = !rsp_calm;
         rsp_hold = draw_gap(rsp_calm);
      end else if (rsp_hold > 0) begin
         rsp_hold--;
      end
      rsp_ready <= (rsp_hold == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      pool_init(0, 9'd256);
      pool_init(1, 9'd256);
      walk_pos = NIL_LINK;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset pool: empty walk, top slot, first alloc
      push_req(MODE_FIRST, 8'd0);
      push_req(MODE_QUERY, 8'd255);
      push_req(MODE_ALLOC, 8'd255);

      // three-slot pool: bad slots, full pool, walk, unlink head/middle/tail
      write_pool_size(9'd3);
      push_req(MODE_FIRST, 8'd0);
      push_req(MODE_NEXT, 8'd0);
      push_req(MODE_QUERY, 8'd255);
      push_req(MODE_FREE, 8'd255);
      push_req(MODE_FREE, 8'd0);
      push_req(MODE_ALLOC, 8'd0);
      push_req(MODE_ALLOC, 8'd0);
      push_req(MODE_ALLOC, 8'd0);
      push_req(MODE_ALLOC, 8'd0);
      push_req(MODE_FIRST, 8'd0);
      push_req(MODE_NEXT, 8'd2);
      push_req(MODE_NEXT, 8'd1);
      push_req(MODE_NEXT, 8'd0);
      push_req(MODE_QUERY, 8'd1);
      push_req(MODE_FREE, 8'd1);
      push_req(MODE_NEXT, 8'd2);
      push_req(MODE_FREE, 8'd2);
      push_req(MODE_FREE, 8'd0);
      push_req(MODE_FREE, 8'd0);
      push_req(MODE_UNDEF_LO, 8'd255);
      push_req(MODE_UNDEF_MID, 8'd0);
      push_req(MODE_UNDEF_HI, 8'd255);

      run_phase(9'd1, 40, 50);
      run_phase(9'd0, 40, 50);
      run_phase(9'd511, 280, 95);
      run_phase(9'd5, 90, 45);
      run_phase(9'd16, 140, 50);
      run_phase(9'd257, 120, 40);
      run_phase(9'd256, 120, 55);
      run_phase(9'($urandom_range(1, 300)), 120, 50);

      wait_drained();
      if (fail_cnt == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
